FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/lmsf_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan frame buffer package
// Geometry constants, operation codes, command and status types, pixel helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsf_pkg;

   // Panel geometry
   localparam int COLUMNS     = 64;
   localparam int SCAN_LINES  = 16;
   localparam int SCREEN_H    = 4 * SCAN_LINES;
   localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W       = $clog2(SCAN_LINES);
   localparam int Y_W         = $clog2(SCREEN_H);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int MEM_DEPTH   = 1 << ADDR_W;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Register indexes on the CSR port
   localparam logic CSR_FLUSH_DIVISOR  = 1'b0;
   localparam logic CSR_DISPLAY_ENABLE = 1'b1;

   typedef enum logic [2:0] {
      OP_SCAN      = 3'd0,
      OP_SET_PIXEL = 3'd1,
      OP_CLEAR_AREA = 3'd2,
      OP_CLEAR_ALL = 3'd3,
      OP_COMMIT    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CMD_SCAN,
      CMD_PIXEL,
      CMD_AREA,
      CMD_CLEAR,
      CMD_COMMIT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [COL_W-1:0] x_first;
      logic [COL_W-1:0] x_last;
      logic [Y_W-1:0]   y_first;
      logic [Y_W-1:0]   y_last;
      logic [1:0]       color;
   } cmd_type;

   typedef struct packed {
      logic [7:0] flush_divisor;
      logic       display_enable;
   } cfg_type;

   typedef struct packed {
      logic init_busy;
   } status_type;

   // Both quadrant bits of one quadrant
   function automatic logic [7:0] quad_mask(input logic [1:0] q);
      return 8'h03 << {q, 1'b0};
   endfunction

   // Update the red and green bits of one quadrant, active low
   function automatic logic [7:0] pixel_merge(input logic [7:0] b, input logic [1:0] q,
                                              input logic [1:0] color);
      logic [7:0] rb;
      logic [7:0] gb;
      logic [7:0] r;
      rb = 8'h01 << {q, 1'b0};
      gb = 8'h02 << {q, 1'b0};
      r  = color[0] ? (b & ~rb) : (b | rb);
      r  = color[1] ? (r & ~gb) : (r | gb);
      return r;
   endfunction

   // Pick one buffer's byte from a word holding both
   function automatic logic [7:0] byte_select(input logic [15:0] word, input logic sel);
      return sel ? word[15:8] : word[7:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/led_matrix_scan_framebuffer.sv
// ----------------------------------------------------------------------------
// LED matrix scan frame buffer
// Double-buffered active-low frame store and row scanner for a 1/16-scan
// red/green LED panel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per item: scan tick, set pixel, clear area,
//   clear all or request commit. Decoded items wait in a two-entry queue, so
//   the request side keeps moving while the store is busy.
//   A scan tick returns 64 items on rsp_*, one row byte per cycle from the
//   frame store read port while rsp_ready stays high; each byte passes
//   through the read data register and then the output register.
//   Set pixel is a read-modify-write in a read state and a write state.
//   Clear area visits one cell per cycle of the clipped rectangle, both
//   buffers at once. Clear all sweeps all 1024 cells of the store.
//   After reset all 1024 cells of the store are swept to dark; req_ready
//   stays low during that pass while the csr_* port is served as usual.
//   If the receiver stalls rsp_ready, the row fetch pauses with the byte in
//   hand and resumes in order once the output register drains.
//   The csr_* port holds flush_divisor at offset 0 and display_enable at 4.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module led_matrix_scan_framebuffer
   import lmsf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [8:0]        req_rect_width,
   input  logic [8:0]        req_rect_height,
   input  logic [1:0]        req_color,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_row_address,
   output logic [5:0]        rsp_column,
   output logic [7:0]        rsp_row_byte,
   output logic              rsp_output_enable,
   output logic              rsp_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg_ff;
   status_type status;
   logic       queue_ready, push, pop, pop_valid;
   cmd_type    push_cmd, pop_cmd;
   logic       csr_write;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flush_divisor  <= 8'd2;
         cfg_ff.display_enable <= 1'b1;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_FLUSH_DIVISOR:  cfg_ff.flush_divisor  <= csr_pwdata[7:0];
            CSR_DISPLAY_ENABLE: cfg_ff.display_enable <= csr_pwdata[0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_FLUSH_DIVISOR:  csr_prdata = {24'd0, cfg_ff.flush_divisor};
         CSR_DISPLAY_ENABLE: csr_prdata = {31'd0, cfg_ff.display_enable};
         default:            csr_prdata = '0;
      endcase
   end

   lmsf_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .status          (status),
      .queue_ready     (queue_ready),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   lmsf_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   lmsf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (pop_valid),
      .cmd               (pop_cmd),
      .cmd_pop           (pop),
      .cfg               (cfg_ff),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row_address   (rsp_row_address),
      .rsp_column        (rsp_column),
      .rsp_row_byte      (rsp_row_byte),
      .rsp_output_enable (rsp_output_enable),
      .rsp_last          (rsp_last)
   );

   // No results while the store is still being initialized
   `ASSERT_IMPLIES(a_no_rsp_during_init, clock, reset, status.init_busy, !rsp_valid)
   // The final byte of a row sits on the last column
   `ASSERT_IMPLIES(a_last_on_final_column, clock, reset, rsp_valid && rsp_last,
                   rsp_column == 6'(COLUMNS - 1))
   // A non-final byte taken is followed by the next column when one is shown
   `ASSERT_NEXT(a_column_advances, clock, reset,
                rsp_valid && rsp_ready && !rsp_last,
                !rsp_valid || (rsp_column == $past(rsp_column) + 6'd1))

endmodule

`default_nettype wire

FILE: rtl/lmsf_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request items, decodes the operation, clips pixels and rectangles
// to the screen and pushes one command per useful item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_front
   import lmsf_pkg::*;
(
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [8:0]        req_rect_width,
   input  logic [8:0]        req_rect_height,
   input  logic [1:0]        req_color,
   input  status_type        status,
   input  logic              queue_ready,
   output logic              push,
   output cmd_type           push_cmd
);

   localparam logic signed [10:0] SCREEN_W_S = 11'(COLUMNS);
   localparam logic signed [10:0] SCREEN_H_S = 11'(SCREEN_H);
   localparam logic signed [10:0] ZERO_S     = 11'sd0;

   logic signed [10:0] x_ext, y_ext, w_ext, h_ext;
   logic signed [10:0] x0, y0, x1, y1, x1c, y1c, x_end, y_end;
   logic               on_screen, area_empty, useful;

   // Take items only once the store is initialized and the queue has room
   assign req_ready = queue_ready && !status.init_busy;

   // Clip to the screen
   always_comb begin
      x_ext = {{2{req_pos_x[8]}}, req_pos_x};
      y_ext = {{2{req_pos_y[8]}}, req_pos_y};
      w_ext = {2'b00, req_rect_width};
      h_ext = {2'b00, req_rect_height};
      x0    = (x_ext < ZERO_S) ? ZERO_S : x_ext;
      y0    = (y_ext < ZERO_S) ? ZERO_S : y_ext;
      x1    = x_ext + w_ext;
      y1    = y_ext + h_ext;
      x1c   = (x1 > SCREEN_W_S) ? SCREEN_W_S : x1;
      y1c   = (y1 > SCREEN_H_S) ? SCREEN_H_S : y1;
      x_end = x1c - 11'sd1;
      y_end = y1c - 11'sd1;
      area_empty = (x1c <= x0) || (y1c <= y0);
      on_screen  = (x_ext >= ZERO_S) && (x_ext < SCREEN_W_S) &&
                   (y_ext >= ZERO_S) && (y_ext < SCREEN_H_S);
   end

   // Classify the operation; drop items that change nothing
   always_comb begin
      push_cmd.kind    = CMD_SCAN;
      push_cmd.x_first = x0[COL_W-1:0];
      push_cmd.x_last  = x_end[COL_W-1:0];
      push_cmd.y_first = y0[Y_W-1:0];
      push_cmd.y_last  = y_end[Y_W-1:0];
      push_cmd.color   = req_color;
      useful           = 1'b0;
      case (op_type'(req_operation))
         OP_SCAN: begin
            push_cmd.kind = CMD_SCAN;
            useful        = 1'b1;
         end
         OP_SET_PIXEL: begin
            push_cmd.kind = CMD_PIXEL;
            useful        = on_screen;
         end
         OP_CLEAR_AREA: begin
            push_cmd.kind = CMD_AREA;
            useful        = !area_empty;
         end
         OP_CLEAR_ALL: begin
            push_cmd.kind = CMD_CLEAR;
            useful        = 1'b1;
         end
         OP_COMMIT: begin
            push_cmd.kind = CMD_COMMIT;
            useful        = 1'b1;
         end
         default: begin
            useful = 1'b0;
         end
      endcase
   end

   assign push = req_valid && req_ready && useful;

endmodule

`default_nettype wire

FILE: rtl/lmsf_cmd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_cmd_queue
   import lmsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lmsf_back.sv
// ----------------------------------------------------------------------------
// Back end
// Owns the dual-buffer frame store and the scan state. Executes queued
// commands: row scans, pixel read-modify-writes, rectangle clears,
// full clears and commits, and drives the registered row byte output.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_back
   import lmsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  cfg_type     cfg,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_row_address,
   output logic [5:0]  rsp_column,
   output logic [7:0]  rsp_row_byte,
   output logic        rsp_output_enable,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_AREA,
      ST_CLEAR
   } state_type;

   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCAN_LINES - 1);

   // Frame store: low byte is buffer 0, high byte is buffer 1
   logic [15:0]       mem [MEM_DEPTH];
   logic [15:0]       rd_data_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [15:0]       wr_data;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              read_select_ff, read_select_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [7:0]        flush_count_ff, flush_count_in;
   logic              commit_pending_ff, commit_pending_in;
   cmd_type           cmd_ff, cmd_in;
   logic [Y_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              issuing_ff, issuing_in;
   logic [3:0]        scan_addr_ff, scan_addr_in;
   logic              pend_ff, pend_in;
   logic [COL_W-1:0]  pend_col_ff, pend_col_in;
   logic              pend_last_ff, pend_last_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [7:0]        wb_mask_ff, wb_mask_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_row_address_ff, rsp_row_address_in;
   logic [5:0]        rsp_column_ff, rsp_column_in;
   logic [7:0]        rsp_row_byte_ff, rsp_row_byte_in;
   logic              rsp_output_enable_ff, rsp_output_enable_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              load;
   logic [7:0]        flush_next;
   logic [7:0]        pix_byte;

   assign status.init_busy  = (state_ff == ST_INIT);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_address   = rsp_row_address_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_row_byte      = rsp_row_byte_ff;
   assign rsp_output_enable = rsp_output_enable_ff;
   assign rsp_last          = rsp_last_ff;

   assign flush_next = flush_count_ff + 8'd1;
   assign pix_byte   = pixel_merge(byte_select(rd_data_ff, !read_select_ff),
                                   cmd_ff.y_first[Y_W-1:ROW_W], cmd_ff.color);

   always_comb begin
      state_in             = state_ff;
      sweep_in             = sweep_ff;
      read_select_in       = read_select_ff;
      scan_row_in          = scan_row_ff;
      flush_count_in       = flush_count_ff;
      commit_pending_in    = commit_pending_ff;
      cmd_in               = cmd_ff;
      row_in               = row_ff;
      col_in               = col_ff;
      issuing_in           = issuing_ff;
      scan_addr_in         = scan_addr_ff;
      pend_in              = pend_ff;
      pend_col_in          = pend_col_ff;
      pend_last_in         = pend_last_ff;
      wb_valid_in          = 1'b0;
      wb_addr_in           = wb_addr_ff;
      wb_mask_in           = wb_mask_ff;
      rsp_valid_in         = rsp_valid_ff;
      rsp_row_address_in   = rsp_row_address_ff;
      rsp_column_in        = rsp_column_ff;
      rsp_row_byte_in      = rsp_row_byte_ff;
      rsp_output_enable_in = rsp_output_enable_ff;
      rsp_last_in          = rsp_last_ff;
      cmd_pop              = 1'b0;
      rd_en                = 1'b0;
      rd_addr              = '0;
      wr_en                = 1'b0;
      wr_addr              = '0;
      wr_data              = '0;

      // Write back a rectangle clear in the cycle after its read
      if (wb_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = wb_addr_ff;
         wr_data = rd_data_ff | {wb_mask_ff, wb_mask_ff};
      end

      // Move a fetched row byte into the output register
      load = pend_ff && (!rsp_valid_ff || rsp_ready);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_row_address_in   = scan_addr_ff;
         rsp_column_in        = 6'(pend_col_ff);
         rsp_row_byte_in      = byte_select(rd_data_ff, read_select_ff);
         rsp_output_enable_in = cfg.display_enable;
         rsp_last_in          = pend_last_ff;
         pend_in              = 1'b0;
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // Sweep the whole store to dark
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = '1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.kind)
                  CMD_COMMIT: begin
                     commit_pending_in = 1'b1;
                  end
                  CMD_SCAN: begin
                     // Count frames at the last row and swap when due
                     scan_addr_in = 4'(scan_row_ff);
                     scan_row_in  = scan_row_ff + 1'b1;
                     if (scan_row_ff == ROW_LAST) begin
                        flush_count_in = flush_next;
                        if (commit_pending_ff && (flush_next >= cfg.flush_divisor)) begin
                           read_select_in    = !read_select_ff;
                           flush_count_in    = '0;
                           commit_pending_in = 1'b0;
                        end
                     end
                     col_in     = '0;
                     issuing_in = 1'b1;
                     state_in   = ST_SCAN;
                  end
                  CMD_PIXEL: begin
                     state_in = ST_PIX_RD;
                  end
                  CMD_AREA: begin
                     row_in   = cmd.y_first;
                     col_in   = cmd.x_first;
                     state_in = ST_AREA;
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Fetch one byte per cycle while the output keeps up
            if (issuing_ff && (!pend_ff || load)) begin
               rd_en        = 1'b1;
               rd_addr      = {scan_row_ff, col_ff};
               pend_in      = 1'b1;
               pend_col_in  = col_ff;
               pend_last_in = (col_ff == COL_LAST);
               col_in       = col_ff + 1'b1;
               if (col_ff == COL_LAST) begin
                  issuing_in = 1'b0;
               end
            end else if (!issuing_ff && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_PIX_RD: begin
            rd_en    = 1'b1;
            rd_addr  = {cmd_ff.y_first[ROW_W-1:0], cmd_ff.x_first};
            state_in = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            // Modify only the write buffer's byte
            wr_en   = 1'b1;
            wr_addr = {cmd_ff.y_first[ROW_W-1:0], cmd_ff.x_first};
            if (read_select_ff) begin
               wr_data = {rd_data_ff[15:8], pix_byte};
            end else begin
               wr_data = {pix_byte, rd_data_ff[7:0]};
            end
            state_in = ST_IDLE;
         end
         ST_AREA: begin
            // Read one cell per cycle, write it back with the quadrant mask
            rd_en       = 1'b1;
            rd_addr     = {row_ff[ROW_W-1:0], col_ff};
            wb_valid_in = 1'b1;
            wb_addr_in  = {row_ff[ROW_W-1:0], col_ff};
            wb_mask_in  = quad_mask(row_ff[Y_W-1:ROW_W]);
            if (col_ff == cmd_ff.x_last) begin
               col_in = cmd_ff.x_first;
               if (row_ff == cmd_ff.y_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_INIT;
         sweep_ff          <= '0;
         read_select_ff    <= 1'b0;
         scan_row_ff       <= '0;
         flush_count_ff    <= '0;
         commit_pending_ff <= 1'b1;
         issuing_ff        <= 1'b0;
         pend_ff           <= 1'b0;
         wb_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         sweep_ff          <= sweep_in;
         read_select_ff    <= read_select_in;
         scan_row_ff       <= scan_row_in;
         flush_count_ff    <= flush_count_in;
         commit_pending_ff <= commit_pending_in;
         issuing_ff        <= issuing_in;
         pend_ff           <= pend_in;
         wb_valid_ff       <= wb_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      cmd_ff               <= cmd_in;
      row_ff               <= row_in;
      col_ff               <= col_in;
      scan_addr_ff         <= scan_addr_in;
      pend_col_ff          <= pend_col_in;
      pend_last_ff         <= pend_last_in;
      wb_addr_ff           <= wb_addr_in;
      wb_mask_ff           <= wb_mask_in;
      rsp_row_address_ff   <= rsp_row_address_in;
      rsp_column_ff        <= rsp_column_in;
      rsp_row_byte_ff      <= rsp_row_byte_in;
      rsp_output_enable_ff <= rsp_output_enable_in;
      rsp_last_ff          <= rsp_last_in;
   end

   // Frame store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/led_matrix_scan_framebuffer_test.sv
// ----------------------------------------------------------------------------
// LED matrix scan frame buffer testbench
// Drives drawing, commit and scan-tick items into the double-buffered panel
// store. A behavioral copy of the store, the buffer swap and the row scanner
// predicts every row byte. A checker compares each byte field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_scan_framebuffer_test;
   import lmsf_pkg::*;

   // Codes that the block must ignore
   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

   // Worst drain: one running clear area plus a full command queue
   localparam int QUIET_CYCLES = 3 * COLUMNS * SCREEN_H + 256;
   localparam int TAIL_CYCLES  = 200;
   localparam longint RUN_LIMIT = 48_000_000;

   typedef struct {
      logic [2:0]        op;
      logic signed [8:0] pos_x;
      logic signed [8:0] pos_y;
      logic [8:0]        width;
      logic [8:0]        height;
      logic [1:0]        color;
   } draw_cmd_type;

   typedef struct {
      logic [3:0] row_address;
      logic [5:0] column;
      logic [7:0] row_byte;
      logic       output_enable;
      logic       last;
   } row_byte_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_operation;
   logic signed [8:0] req_pos_x;
   logic signed [8:0] req_pos_y;
   logic [8:0]        req_rect_width;
   logic [8:0]        req_rect_height;
   logic [1:0]        req_color;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [3:0]        rsp_row_address;
   logic [5:0]        rsp_column;
   logic [7:0]        rsp_row_byte;
   logic              rsp_output_enable;
   logic              rsp_last;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Panel model: both buffers, scanner and swap state, register copies
   logic [7:0] panel_mem [0:1][0:SCAN_LINES-1][0:COLUMNS-1];
   logic       read_sel;
   logic [3:0] scan_row;
   logic [7:0] flush_cnt;
   logic       swap_pending;
   logic [7:0] divisor_copy;
   logic       panel_lit;

   row_byte_type row_bytes_due [$];
   int           mismatch_count = 0;
   int           steady_left = 0;

   led_matrix_scan_framebuffer DUT (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Count a mismatch, print only the first few
   task automatic log_mismatch(input string field, input int got, input int want);
      if (mismatch_count < 40)
         $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Fill every byte of both buffers with dark
   task automatic darken_panel();
      for (int b = 0; b < 2; b++)
         for (int r = 0; r < SCAN_LINES; r++)
            for (int c = 0; c < COLUMNS; c++)
               panel_mem[b][r][c] = 8'hFF;
   endtask

   // Apply one accepted item to the panel model, queue the row it emits
   task automatic predict_panel(input draw_cmd_type cmd);
      int           xi;
      int           yi;
      int           x_end;
      int           y_end;
      int           quad;
      logic [7:0]   cur;
      logic [7:0]   red_bit;
      logic [7:0]   green_bit;
      logic [7:0]   mask;
      logic [3:0]   addr;
      row_byte_type rb;
      xi = cmd.pos_x;
      yi = cmd.pos_y;
      case (cmd.op)
         OP_SET_PIXEL: begin
            // ignore pixels off the screen
            if (xi >= 0 && xi < COLUMNS && yi >= 0 && yi < SCREEN_H) begin
               quad      = yi / SCAN_LINES;
               red_bit   = 8'h01 << (2 * quad);
               green_bit = 8'h02 << (2 * quad);
               cur = panel_mem[!read_sel][yi % SCAN_LINES][xi];
               cur = cmd.color[0] ? (cur & ~red_bit) : (cur | red_bit);
               cur = cmd.color[1] ? (cur & ~green_bit) : (cur | green_bit);
               panel_mem[!read_sel][yi % SCAN_LINES][xi] = cur;
            end
         end
         OP_CLEAR_AREA: begin
            // clip the rectangle to the screen, clear it in both buffers
            x_end = xi + int'(cmd.width);
            y_end = yi + int'(cmd.height);
            if (x_end > COLUMNS) x_end = COLUMNS;
            if (y_end > SCREEN_H) y_end = SCREEN_H;
            if (xi < 0) xi = 0;
            if (yi < 0) yi = 0;
            for (int b = 0; b < 2; b++)
               for (int r = yi; r < y_end; r++) begin
                  mask = 8'h03 << (2 * (r / SCAN_LINES));
                  for (int c = xi; c < x_end; c++)
                     panel_mem[b][r % SCAN_LINES][c] = panel_mem[b][r % SCAN_LINES][c] | mask;
               end
         end
         OP_CLEAR_ALL: darken_panel();
         OP_COMMIT:    swap_pending = 1'b1;
         OP_SCAN: begin
            // count a frame at row 15, swap when a commit is due
            addr = scan_row;
            if (scan_row == 4'd15) begin
               flush_cnt = flush_cnt + 8'd1;
               if (swap_pending && flush_cnt >= divisor_copy) begin
                  read_sel     = !read_sel;
                  flush_cnt    = 8'd0;
                  swap_pending = 1'b0;
               end
            end
            scan_row = scan_row + 4'd1;
            for (int c = 0; c < COLUMNS; c++) begin
               rb.row_address   = addr;
               rb.column        = 6'(c);
               rb.row_byte      = panel_mem[read_sel][scan_row][c];
               rb.output_enable = panel_lit;
               rb.last          = (c == COLUMNS - 1);
               row_bytes_due.push_back(rb);
            end
         end
         default: ;
      endcase
   endtask

   function automatic draw_cmd_type make_cmd(input logic [2:0] op, input logic [8:0] x,
                                             input logic [8:0] y, input logic [8:0] w,
                                             input logic [8:0] h, input logic [1:0] color);
      draw_cmd_type cmd;
      cmd.op     = op;
      cmd.pos_x  = x;
      cmd.pos_y  = y;
      cmd.width  = w;
      cmd.height = h;
      cmd.color  = color;
      return cmd;
   endfunction

   function automatic logic [8:0] any9();
      return 9'($urandom_range(0, 511));
   endfunction

   // Scan tick with junk in the unused fields
   function automatic draw_cmd_type tick_cmd();
      return make_cmd(OP_SCAN, any9(), any9(), any9(), any9(), 2'($urandom_range(0, 3)));
   endfunction

   // Mostly on-screen pixels and small rectangles, a few of full range
   function automatic draw_cmd_type draw_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return make_cmd(OP_SET_PIXEL, 9'($urandom_range(0, 63)), 9'($urandom_range(0, 63)),
                         any9(), any9(), 2'($urandom_range(0, 3)));
      else if (pick < 70)
         return make_cmd(OP_SET_PIXEL, any9(), any9(), any9(), any9(),
                         2'($urandom_range(0, 3)));
      else if (pick < 95)
         return make_cmd(OP_CLEAR_AREA, 9'($urandom_range(0, 78) - 8),
                         9'($urandom_range(0, 78) - 8), 9'($urandom_range(0, 20)),
                         9'($urandom_range(0, 20)), 2'($urandom_range(0, 3)));
      else
         return make_cmd(OP_CLEAR_AREA, any9(), any9(), any9(), any9(),
                         2'($urandom_range(0, 3)));
   endfunction

   // Any code, any field
   function automatic draw_cmd_type noise_cmd();
      return make_cmd(3'($urandom_range(0, 7)), any9(), any9(), any9(), any9(),
                      2'($urandom_range(0, 3)));
   endfunction

   // Sender idle length: mostly none, some short, a few long, with quiet stretches
   function automatic int pick_gap();
      int pick;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one item and hold it until accepted; valid stays high afterwards
   task automatic send_cmd(input draw_cmd_type cmd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= cmd.op;
      req_pos_x       <= cmd.pos_x;
      req_pos_y       <= cmd.pos_y;
      req_rect_width  <= cmd.width;
      req_rect_height <= cmd.height;
      req_color       <= cmd.color;
      do @(posedge clock); while (!req_ready);
      predict_panel(cmd);
   endtask

   // Drop valid and hold until every queued row byte has come back
   task automatic wait_rows_drained();
      req_valid <= 1'b0;
      while (row_bytes_due.size() != 0) @(posedge clock);
   endtask

   // Let any clear still running finish before touching a register
   task automatic settle_before_write();
      wait_rows_drained();
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic write_register(input logic index, input logic [31:0] value);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == CSR_FLUSH_DIVISOR) begin
         divisor_copy = value[7:0];
         want         = {24'd0, value[7:0]};
      end else begin
         panel_lit = value[0];
         want      = {31'd0, value[0]};
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         log_mismatch("register readback", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Compare each accepted row byte with the oldest prediction
   always @(posedge clock) begin
      row_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_bytes_due.size() == 0) begin
            log_mismatch("unexpected row byte, column", rsp_column, 0);
         end else begin
            want = row_bytes_due.pop_front();
            if (rsp_row_address !== want.row_address)
               log_mismatch("row_address", rsp_row_address, want.row_address);
            if (rsp_column !== want.column)
               log_mismatch("column", rsp_column, want.column);
            if (rsp_row_byte !== want.row_byte)
               log_mismatch("row_byte", rsp_row_byte, want.row_byte);
            if (rsp_output_enable !== want.output_enable)
               log_mismatch("output_enable", rsp_output_enable, want.output_enable);
            if (rsp_last !== want.last)
               log_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Receiver: free-running stretches, short stalls and a few long ones
   initial begin
      int pick;
      int low_n;
      int high_n;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            low_n  = 0;
            high_n = $urandom_range(50, 300);
         end else if (pick < 85) begin
            low_n  = $urandom_range(0, 3);
            high_n = $urandom_range(1, 6);
         end else begin
            low_n  = $urandom_range(10, 60);
            high_n = $urandom_range(1, 6);
         end
         if (low_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (low_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (high_n) @(posedge clock);
      end
   end

   // Corners, off-screen pixels, clipping, ignored codes, one full frame
   task automatic test_directed_ops();
      // commit is pending out of reset, so divisor zero swaps at the first row 15
      write_register(CSR_FLUSH_DIVISOR, 32'd0);
      send_cmd(make_cmd(OP_SET_PIXEL, 0, 0, 0, 0, 2'd3));
      send_cmd(make_cmd(OP_SET_PIXEL, 63, 0, 511, 511, 2'd1));
      send_cmd(make_cmd(OP_SET_PIXEL, 17, 16, 0, 0, 2'd2));
      send_cmd(make_cmd(OP_SET_PIXEL, 40, 48, 0, 0, 2'd3));
      // off the screen on the left, on the right and below
      send_cmd(make_cmd(OP_SET_PIXEL, -1, 0, 0, 0, 2'd3));
      send_cmd(make_cmd(OP_SET_PIXEL, 64, 0, 0, 0, 2'd3));
      send_cmd(make_cmd(OP_SET_PIXEL, 0, 64, 0, 0, 2'd3));
      send_cmd(make_cmd(OP_RESERVED_FIRST, 255, 255, 511, 511, 2'd3));
      send_cmd(make_cmd(OP_RESERVED_LAST, 0, 0, 1, 1, 2'd0));
      // clipped on top and right, then an empty one
      send_cmd(make_cmd(OP_CLEAR_AREA, 60, -4, 511, 5, 2'd0));
      send_cmd(make_cmd(OP_CLEAR_AREA, -256, -256, 0, 511, 2'd0));
      send_cmd(make_cmd(OP_COMMIT, 0, 0, 0, 0, 2'd0));
      repeat (SCAN_LINES) send_cmd(tick_cmd());
   endtask

   // Largest divisor with the panel blanked, then divisor one lit
   task automatic test_register_extremes();
      settle_before_write();
      write_register(CSR_FLUSH_DIVISOR, 32'd255);
      write_register(CSR_DISPLAY_ENABLE, 32'd0);
      repeat (4) send_cmd(draw_cmd());
      send_cmd(make_cmd(OP_CLEAR_ALL, any9(), any9(), any9(), any9(), 2'd3));
      repeat (3) send_cmd(draw_cmd());
      send_cmd(make_cmd(OP_COMMIT, any9(), any9(), any9(), any9(), 2'd1));
      repeat (18) send_cmd(tick_cmd());
      settle_before_write();
      write_register(CSR_FLUSH_DIVISOR, 32'd1);
      write_register(CSR_DISPLAY_ENABLE, 32'd1);
      repeat (6) send_cmd(draw_cmd());
      send_cmd(make_cmd(OP_COMMIT, 0, 0, 0, 0, 2'd0));
      repeat (2 * SCAN_LINES + 2) send_cmd(tick_cmd());
   endtask

   // Draw-commit-scan sequences with random content, plus noise bursts
   task automatic test_random_frames(input int phases, input int items_per_phase);
      int sent;
      int n;
      logic [31:0] div;
      for (int p = 0; p < phases; p++) begin
         settle_before_write();
         case ($urandom_range(0, 3))
            0:       div = 32'd0;
            1:       div = 32'd1;
            2:       div = 32'd2;
            default: div = $urandom_range(3, 255);
         endcase
         write_register(CSR_FLUSH_DIVISOR, div);
         write_register(CSR_DISPLAY_ENABLE, 32'($urandom_range(0, 1)));
         sent = 0;
         while (sent < items_per_phase) begin
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 4);
               repeat (n) send_cmd(noise_cmd());
               sent += n;
            end else begin
               n = $urandom_range(1, 6);
               repeat (n) send_cmd(draw_cmd());
               send_cmd(make_cmd(OP_COMMIT, any9(), any9(), any9(), any9(),
                                 2'($urandom_range(0, 3))));
               sent += n + 1;
               n = $urandom_range(4, 24);
               repeat (n) send_cmd(tick_cmd());
               sent += n;
            end
            // hold off now and then until the scanner has caught up
            if ($urandom_range(0, 9) == 0)
               wait_rows_drained();
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_SCAN;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_rect_width  = '0;
      req_rect_height = '0;
      req_color       = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      darken_panel();
      read_sel     = 1'b0;
      scan_row     = 4'd0;
      flush_cnt    = 8'd0;
      swap_pending = 1'b1;
      divisor_copy = 8'd2;
      panel_lit    = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_register_extremes();
      test_random_frames(4, 54);

      wait_rows_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("led_matrix_scan_framebuffer_test: done, clean");
      else
         $display("led_matrix_scan_framebuffer_test: done, errors");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(RUN_LIMIT);
      $display("led_matrix_scan_framebuffer_test: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/lmsf_pkg.sv
rtl/lmsf_front.sv
rtl/lmsf_cmd_queue.sv
rtl/lmsf_back.sv
rtl/led_matrix_scan_framebuffer.sv
tb/sv/led_matrix_scan_framebuffer_test.sv
